// ===== rtl/core/fcie_pkg.sv =====
package fcie_pkg;

   localparam int CharWidth = 8;
   localparam int AddrHalfWidth = 64;

   typedef enum logic [2:0] {
      SYN_BETWEEN = 3'd0,
      SYN_KEY     = 3'd1,
      SYN_BEFORE  = 3'd2,
      SYN_TOKEN   = 3'd3,
      SYN_QUOTED  = 3'd4
   } syn_state_type;

   localparam logic [2:0] KEY_NONE = 3'd0;
   localparam logic [2:0] KEY_F    = 3'd1;
   localparam logic [2:0] KEY_FO   = 3'd2;
   localparam logic [2:0] KEY_FOR  = 3'd3;
   localparam logic [2:0] KEY_FAIL = 3'd4;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_PUBLIC  = 2'd1;
   localparam logic [1:0] STATUS_PRIVATE = 2'd2;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   // Byte address width; the register index is the word address above bits 1:0.
   localparam int CsrAddrWidth = 3;
   localparam logic [0:0] REG_PARSE_MODE = 1'b0;

   typedef struct packed {
      logic [2:0] octets;
      logic       saw_digit;
      logic       bad;
   } v4_info_type;

   typedef struct packed {
      logic [3:0]  count;
      logic [3:0]  gap_pos;
      logic        has_gap;
      logic [2:0]  xdigits;
      logic [15:0] val;
      logic [1:0]  nchars;
      logic        lead;
      logic        colon_end;
      logic        tail;
      logic        bad;
   } v6_info_type;

   typedef struct packed {
      logic       started;
      logic       bracket;
      logic       closed;
      logic [1:0] colons;
      logic       prefix_ok;
   } tok_flags_type;

   typedef struct packed {
      logic found;
      logic is_public;
      logic is_v6;
   } best_info_type;

   // Complete candidate state between the input and result registers.
   typedef struct packed {
      tok_flags_type tok;
      logic [31:0]   prefix_v4;
      logic [23:0]   v4_accum;
      logic [8:0]    v4_part;
      v4_info_type   v4;
      logic [127:0]  groups;
      v6_info_type   v6;
   } cand_type;

   typedef struct packed {
      logic        ok;
      logic        is_v6;
      logic [63:0] hi;
      logic [63:0] lo;
   } cand_result_type;

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_SEMI) || (c == CH_COMMA);
   endfunction

   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h61 + 8'd10)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h41 + 8'd10)};
      return r;
   endfunction

endpackage

// ===== rtl/core/fcie_cand.sv =====
module fcie_cand
   import fcie_pkg::*;
(
   input  cand_type        cand_q,
   input  logic            restart,
   input  logic            feed,
   input  logic [7:0]      char_byte,
   output cand_type        cand_d,
   output cand_result_type result
);

   cand_type        base;
   cand_type        nx;
   logic [4:0]      hx;
   logic [8:0]      nv;
   logic            v4_ok_base;
   logic            v4_restart;
   logic            do_addr;
   logic            v6_skip;

   always_comb begin
      base = cand_q;
      if (restart) base = '0;
      nx = base;
      hx = hex_of(char_byte);
      v4_ok_base = !base.v4.bad && base.v4.octets == 3'd4;
      do_addr = 1'b0;
      v4_restart = 1'b0;
      nv = '0;
      v6_skip = 1'b0;
      if (feed) begin
         if (!base.tok.started) begin
            nx.tok.started = 1'b1;
         end
         if (!base.tok.started && char_byte == CH_LBRACK) begin
            nx.tok.bracket = 1'b1;
         end else if (base.tok.bracket) begin
            if (!base.tok.closed) begin
               if (char_byte == CH_RBRACK) nx.tok.closed = 1'b1;
               else do_addr = 1'b1;
            end
         end else begin
            if (char_byte == CH_COLON) begin
               if (base.tok.colons == 2'd0) begin
                  nx.tok.prefix_ok = v4_ok_base;
                  nx.prefix_v4 = {base.v4_accum, base.v4_part[7:0]};
               end
               if (base.tok.colons < 2'd2) nx.tok.colons = base.tok.colons + 2'd1;
            end
            do_addr = 1'b1;
         end
      end
      if (do_addr) begin
         // IPv4 side
         if (char_byte == CH_COLON && !base.v6.tail) begin
            nx.v4_accum = '0;
            nx.v4_part = '0;
            nx.v4 = '0;
            v4_restart = 1'b1;
         end else if (!base.v4.bad) begin
            if (hx[4] == 1'b0 && char_byte >= 8'h30 && char_byte <= 8'h39) begin
               nv = 9'(base.v4_part * 9'd10) + 9'(hx[3:0]);
               if ((base.v4.saw_digit && base.v4_part == 9'd0) || base.v4_part > 9'd25
                   || nv > 9'd255) begin
                  nx.v4.bad = 1'b1;
               end else begin
                  nx.v4_part = nv;
                  if (!base.v4.saw_digit) begin
                     nx.v4.octets = base.v4.octets + 3'd1;
                     if (base.v4.octets >= 3'd4) nx.v4.bad = 1'b1;
                     else nx.v4.saw_digit = 1'b1;
                  end
               end
            end else if (char_byte == CH_DOT && base.v4.saw_digit) begin
               if (base.v4.octets >= 3'd4) nx.v4.bad = 1'b1;
               else begin
                  nx.v4_accum = {base.v4_accum[15:0], base.v4_part[7:0]};
                  nx.v4_part = '0;
                  nx.v4.saw_digit = 1'b0;
               end
            end else begin
               nx.v4.bad = 1'b1;
            end
         end
         // IPv6 side; the dotted tail check uses the IPv4 bad flag after its update
         if (!base.v6.bad) begin
            if (base.v6.nchars == 2'd0 && char_byte == CH_COLON) begin
               nx.v6.lead = 1'b1;
               nx.v6.nchars = 2'd1;
               v6_skip = 1'b1;
            end else if (base.v6.nchars == 2'd1 && base.v6.lead && char_byte != CH_COLON) begin
               nx.v6.bad = 1'b1;
               v6_skip = 1'b1;
            end
            if (!v6_skip) begin
               if (base.v6.nchars < 2'd2) nx.v6.nchars = base.v6.nchars + 2'd1;
               if (!base.v6.tail) begin
                  nx.v6.colon_end = 1'b0;
                  if (!hx[4]) begin
                     if (base.v6.xdigits >= 3'd4) nx.v6.bad = 1'b1;
                     else begin
                        nx.v6.val = {base.v6.val[11:0], hx[3:0]};
                        nx.v6.xdigits = base.v6.xdigits + 3'd1;
                     end
                  end else if (char_byte == CH_COLON) begin
                     if (base.v6.xdigits == 3'd0) begin
                        if (base.v6.has_gap) nx.v6.bad = 1'b1;
                        else begin
                           nx.v6.has_gap = 1'b1;
                           nx.v6.gap_pos = base.v6.count;
                        end
                     end else if (base.v6.count >= 4'd8) begin
                        nx.v6.bad = 1'b1;
                     end else begin
                        nx.groups[16*(7-base.v6.count[2:0]) +: 16] = base.v6.val;
                        nx.v6.count = base.v6.count + 4'd1;
                        nx.v6.val = '0;
                        nx.v6.xdigits = '0;
                        nx.v6.colon_end = 1'b1;
                     end
                  end else if (char_byte == CH_DOT && base.v6.count <= 4'd6
                               && !nx.v4.bad && !v4_restart) begin
                     nx.v6.tail = 1'b1;
                     nx.v6.xdigits = '0;
                  end else begin
                     nx.v6.bad = 1'b1;
                  end
               end
            end
         end
      end
      cand_d = nx;
   end

   // Evaluation of the updated candidate.
   logic [127:0] g;
   logic [127:0] gs;
   logic [3:0]   n;
   logic [3:0]   k;
   logic         v6_ok;
   logic [31:0]  v4v;
   logic [63:0]  hi;
   logic [63:0]  lo;

   always_comb begin
      g = nx.groups;
      n = nx.v6.count;
      v4v = {nx.v4_accum, nx.v4_part[7:0]};
      v6_ok = !(nx.v6.bad || nx.v6.nchars == 2'd0 || (nx.v6.lead && nx.v6.nchars < 2'd2)
                || nx.v6.colon_end || n > 4'd8);
      if (nx.v6.tail) begin
         if (!(!nx.v4.bad && nx.v4.octets == 3'd4) || n > 4'd6) v6_ok = 1'b0;
         else begin
            g[16*(7-n[2:0]) +: 16] = v4v[31:16];
            g[16*(6-n[2:0]) +: 16] = v4v[15:0];
         end
         n = n + 4'd2;
      end else if (nx.v6.xdigits != 3'd0) begin
         if (n >= 4'd8) v6_ok = 1'b0;
         else g[16*(7-n[2:0]) +: 16] = nx.v6.val;
         n = n + 4'd1;
      end
      gs = g;
      k = '0;
      if (nx.v6.has_gap) begin
         if (n >= 4'd8 || nx.v6.gap_pos > n) v6_ok = 1'b0;
         else begin
            k = n - nx.v6.gap_pos;
            // groups below gap stay; the k groups at gap move to the end
            for (int i = 0; i < 8; i++) begin
               if (i >= 8 - k) gs[16*(7-i) +: 16] = g[16*(7-(i-(8-k)-0+nx.v6.gap_pos)) +: 16];
               else if (i >= nx.v6.gap_pos) gs[16*(7-i) +: 16] = 16'h0;
            end
         end
         n = 4'd8;
      end
      if (n != 4'd8) v6_ok = 1'b0;
      hi = gs[127:64];
      lo = gs[63:0];
      result = '0;
      if (nx.tok.bracket) begin
         result.ok = nx.tok.closed && v6_ok;
         result.is_v6 = 1'b1;
         result.hi = hi;
         result.lo = lo;
      end else if (nx.tok.colons == 2'd0) begin
         result.ok = !nx.v4.bad && nx.v4.octets == 3'd4;
         result.lo = {32'h0, v4v};
      end else if (nx.tok.colons == 2'd1) begin
         result.ok = nx.tok.prefix_ok;
         result.lo = {32'h0, nx.prefix_v4};
      end else begin
         result.ok = v6_ok;
         result.is_v6 = 1'b1;
         result.hi = hi;
         result.lo = lo;
      end
      if (result.is_v6 && result.hi == 64'h0 && result.lo[63:32] == 32'h0000FFFF) begin
         result.is_v6 = 1'b0;
         result.lo = {32'h0, result.lo[31:0]};
      end
   end

endmodule

// ===== rtl/core/fcie_select.sv =====
module fcie_select
   import fcie_pkg::*;
(
   input  best_info_type   best_q,
   input  logic [63:0]     best_hi_q,
   input  logic [63:0]     best_lo_q,
   input  logic            eval,
   input  cand_result_type cand,
   output best_info_type   best_d,
   output logic [63:0]     best_hi_d,
   output logic [63:0]     best_lo_d
);

   logic priv;
   logic [31:0] a;
   logic [15:0] top;

   always_comb begin
      a = cand.lo[31:0];
      top = cand.hi[63:48];
      if (cand.is_v6) begin
         priv = (cand.hi == 64'h0 && cand.lo == 64'h1) || ((top & 16'hFFC0) == 16'hFE80)
                || ((top & 16'hFFC0) == 16'hFEC0) || ((top[15:8] & 8'hFE) == 8'hFC);
      end else begin
         priv = (a & 32'hFF000000) == 32'h0A000000 || (a & 32'hFFF00000) == 32'hAC100000
                || (a & 32'hFFFF0000) == 32'hC0A80000 || (a & 32'hFF000000) == 32'h7F000000
                || (a & 32'hFFFF0000) == 32'hA9FE0000 || (a & 32'hFFC00000) == 32'h64400000;
      end
      best_d = best_q;
      best_hi_d = best_hi_q;
      best_lo_d = best_lo_q;
      if (eval && cand.ok && !(best_q.found && best_q.is_public) && (!priv || !best_q.found))
      begin
         best_d.found = 1'b1;
         best_d.is_public = !priv;
         best_d.is_v6 = cand.is_v6;
         best_hi_d = cand.hi;
         best_lo_d = cand.lo;
      end
   end

endmodule

// ===== rtl/core/forwarded_client_ip_extractor.sv =====
// Channel  | Direction | Payload
// req      | in        | tdata[7:0] char_byte, tlast is_last
// rsp      | out       | tdata[1:0] status, [2] is_v6, [66:3] addr_high, [130:67] addr_low
// csr      | in        | register 0 parse_mode (bit 0)
// One byte is accepted per cycle while req_tready is high; the parser state updates in the cycle it is taken.
// The result for a header value is registered when its last byte is taken and shown from that register.
// A waiting result stalls req only if another last byte arrives before rsp is taken.
// Reset is synchronous and returns to the start of a header value with parse_mode 0.
module forwarded_client_ip_extractor
   import fcie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // char_byte
   input  logic          req_tlast,   // is_last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // status, is_v6, addr_high, addr_low, zero pad
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   logic            mode_ff;
   syn_state_type   syn_ff, syn_in;
   logic [2:0]      key_ff, key_in;
   logic            want_ff, want_in;
   logic            esc_ff, esc_in;
   cand_type        cand_ff, cand_in;
   best_info_type   best_ff, best_in, best_sel;
   logic [63:0]     hi_ff, hi_in, lo_ff, lo_in, hi_sel, lo_sel;
   logic            out_v_ff, out_v_in;
   logic [135:0]    out_ff;
   logic            c_restart, c_feed, c_eval;
   logic            acc, cfg_wr, mode_wr;
   logic [7:0]      c, lc;
   cand_type        cand_new;
   cand_result_type cres;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'h0, mode_ff};
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign mode_wr = cfg_wr && csr_paddr[2] == REG_PARSE_MODE;
   assign req_tready = !out_v_ff || rsp_tready || !req_tlast;
   assign acc = req_tvalid && req_tready;
   assign out_v_in = (acc && req_tlast && !mode_wr) || (out_v_ff && !rsp_tready);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;
   assign c = req_tdata;
   assign lc = c | 8'h20;

   always_comb begin
      syn_in = syn_ff; key_in = key_ff; want_in = want_ff; esc_in = esc_ff;
      c_restart = 1'b0; c_feed = 1'b0; c_eval = 1'b0;
      if (!mode_ff) begin
         case (syn_ff)
            SYN_BETWEEN: begin
               if (!is_delim(c)) begin
                  key_in = (lc == 8'h66) ? KEY_F : KEY_FAIL;
                  syn_in = SYN_KEY;
               end
            end
            SYN_KEY: begin
               if (c == CH_EQUAL) begin
                  want_in = (key_ff == KEY_FOR);
                  syn_in = SYN_BEFORE;
               end else if (key_ff == KEY_F && lc == 8'h6F) key_in = KEY_FO;
               else if (key_ff == KEY_FO && lc == 8'h72) key_in = KEY_FOR;
               else key_in = KEY_FAIL;
            end
            SYN_BEFORE: begin
               if (c == CH_QUOTE) begin
                  c_restart = 1'b1; esc_in = 1'b0; syn_in = SYN_QUOTED;
               end else if (is_delim(c)) syn_in = SYN_BETWEEN;
               else begin
                  c_restart = 1'b1; c_feed = 1'b1; syn_in = SYN_TOKEN;
               end
            end
            SYN_TOKEN: begin
               if (is_delim(c)) begin
                  c_eval = want_ff; syn_in = SYN_BETWEEN;
               end else begin
                  c_feed = 1'b1; c_eval = req_tlast && want_ff;
               end
            end
            SYN_QUOTED: begin
               if (esc_ff) begin
                  c_feed = 1'b1; esc_in = 1'b0;
               end else if (c == CH_QUOTE) begin
                  c_eval = want_ff; syn_in = SYN_BETWEEN;
               end else begin
                  if (c == CH_BSLASH) esc_in = 1'b1;
                  c_feed = 1'b1;
               end
            end
            default: syn_in = SYN_BETWEEN;
         endcase
      end else begin
         if (syn_ff != SYN_TOKEN) begin
            if (c != CH_SPACE && c != CH_COMMA) begin
               c_restart = 1'b1; c_feed = 1'b1; syn_in = SYN_TOKEN;
            end
         end else if (c == CH_COMMA) begin
            c_eval = 1'b1; syn_in = SYN_BETWEEN;
         end else c_feed = 1'b1;
         if (req_tlast && syn_in == SYN_TOKEN) c_eval = 1'b1;
      end
   end

   fcie_cand u_cand (
      .cand_q(cand_ff), .restart(c_restart), .feed(c_feed), .char_byte(c),
      .cand_d(cand_new), .result(cres)
   );

   fcie_select u_sel (
      .best_q(best_ff), .best_hi_q(hi_ff), .best_lo_q(lo_ff), .eval(c_eval),
      .cand(cres), .best_d(best_sel), .best_hi_d(hi_sel), .best_lo_d(lo_sel)
   );

   always_comb begin
      cand_in = cand_new;
      best_in = best_sel; hi_in = hi_sel; lo_in = lo_sel;
      if (req_tlast) begin
         best_in = '0; hi_in = '0; lo_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         syn_ff <= SYN_BETWEEN; key_ff <= KEY_NONE; want_ff <= 1'b0; esc_ff <= 1'b0;
         cand_ff <= '0; best_ff <= '0; hi_ff <= '0; lo_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         if (mode_wr) begin
            mode_ff <= csr_pwdata[0];
            syn_ff <= SYN_BETWEEN; key_ff <= KEY_NONE; want_ff <= 1'b0; esc_ff <= 1'b0;
            cand_ff <= '0; best_ff <= '0; hi_ff <= '0; lo_ff <= '0;
         end else if (acc) begin
            if (req_tlast) begin
               syn_ff <= SYN_BETWEEN; key_ff <= KEY_NONE; want_ff <= 1'b0; esc_ff <= 1'b0;
               cand_ff <= '0;
            end else begin
               syn_ff <= syn_in; key_ff <= key_in; want_ff <= want_in; esc_ff <= esc_in;
               cand_ff <= cand_in;
            end
            best_ff <= best_in; hi_ff <= hi_in; lo_ff <= lo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc && req_tlast) begin
         if (best_sel.found)
            out_ff <= {5'h0, lo_sel, hi_sel, best_sel.is_v6,
                       best_sel.is_public ? STATUS_PUBLIC : STATUS_PRIVATE};
         else
            out_ff <= {5'h0, 128'h0, 1'b0, STATUS_NONE};
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status code");
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_NONE |-> rsp_tdata[135:2] == '0)
      else $error("empty result carries data");
`endif

endmodule

// ===== test/forwarded_client_ip_extractor_test.sv =====
module forwarded_client_ip_extractor_test;
   import fcie_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } byte_item;

   typedef struct packed {
      logic [1:0]  status;
      logic        is_v6;
      logic [63:0] hi;
      logic [63:0] lo;
   } addr_result;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;
   logic          req_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [135:0]  rsp_tdata;   // status, is_v6, addr_high, addr_low, zero pad
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   forwarded_client_ip_extractor dut (.*);

   byte_item   pending_bytes[$];
   addr_result expected_addrs[$];
   int         error_count;
   int         header_count;
   int         public_count;
   int         private_count;
   int         none_count;
   int         v6_count;
   longint     cycle_count;
   bit         idle_free;
   bit         stimulus_done;

   // Predictor state.
   bit              mode;
   syn_state_type   syn;
   logic [2:0]      key;
   bit              want;
   bit              esc;
   logic [23:0]     v4_acc;
   logic [8:0]      v4_part;
   v4_info_type     v4;
   logic [15:0]     groups[8];
   v6_info_type     v6;
   tok_flags_type   tok;
   logic [31:0]     prefix;
   logic [63:0]     best_hi;
   logic [63:0]     best_lo;
   best_info_type   best;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [135:0] got, input logic [135:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      error_count++;
   endtask

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic logic [31:0] v4_word();
      return {v4_acc, v4_part[7:0]};
   endfunction

   function automatic bit v4_done();
      return !v4.bad && v4.octets == 4;
   endfunction

   function automatic void v4_clear();
      v4_acc = 0;
      v4_part = 0;
      v4 = '0;
   endfunction

   function automatic void v4_take(input logic [7:0] c);
      int nv;
      if (v4.bad) return;
      if (c >= "0" && c <= "9") begin
         nv = v4_part * 10 + (c - "0");
         if ((v4.saw_digit && v4_part == 0) || nv > 255) begin
            v4.bad = 1;
            return;
         end
         v4_part = nv;
         if (!v4.saw_digit) begin
            v4.octets++;
            if (v4.octets > 4) begin
               v4.bad = 1;
               return;
            end
            v4.saw_digit = 1;
         end
      end else if (c == CH_DOT && v4.saw_digit) begin
         if (v4.octets >= 4) begin
            v4.bad = 1;
            return;
         end
         v4_acc = {v4_acc[15:0], v4_part[7:0]};
         v4_part = 0;
         v4.saw_digit = 0;
      end else begin
         v4.bad = 1;
      end
   endfunction

   function automatic void v6_take(input logic [7:0] c);
      int d;
      if (v6.bad) return;
      if (v6.nchars == 0 && c == CH_COLON) begin
         v6.lead = 1;
         v6.nchars = 1;
         return;
      end
      if (v6.nchars == 1 && v6.lead && c != CH_COLON) begin
         v6.bad = 1;
         return;
      end
      if (v6.nchars < 2) v6.nchars++;
      if (v6.tail) return;
      v6.colon_end = 0;
      d = hex_digit(c);
      if (d >= 0) begin
         if (v6.xdigits >= 4) begin
            v6.bad = 1;
            return;
         end
         v6.val = {v6.val[11:0], 4'(d)};
         v6.xdigits++;
      end else if (c == CH_COLON) begin
         if (v6.xdigits == 0) begin
            if (v6.has_gap) begin
               v6.bad = 1;
               return;
            end
            v6.has_gap = 1;
            v6.gap_pos = v6.count;
         end else begin
            if (v6.count >= 8) begin
               v6.bad = 1;
               return;
            end
            groups[v6.count] = v6.val;
            v6.count++;
            v6.val = 0;
            v6.xdigits = 0;
            v6.colon_end = 1;
         end
      end else if (c == CH_DOT && v6.count <= 6 && !v4.bad) begin
         v6.tail = 1;
         v6.xdigits = 0;
      end else begin
         v6.bad = 1;
      end
   endfunction

   function automatic bit v6_assemble(output logic [15:0] g[8]);
      int n, k, i;
      logic [15:0] t[8];
      logic [31:0] w;
      for (i = 0; i < 8; i++) g[i] = groups[i];
      if (v6.bad || v6.nchars == 0 || (v6.lead && v6.nchars < 2) || v6.colon_end) return 0;
      n = v6.count;
      if (n > 8) return 0;
      if (v6.tail) begin
         if (!v4_done() || n > 6) return 0;
         w = v4_word();
         g[n] = w[31:16];
         g[n+1] = w[15:0];
         n += 2;
      end else if (v6.xdigits > 0) begin
         if (n >= 8) return 0;
         g[n] = v6.val;
         n++;
      end
      if (v6.has_gap) begin
         if (n >= 8 || v6.gap_pos > n) return 0;
         k = n - v6.gap_pos;
         for (i = 0; i < 8; i++) t[i] = 0;
         for (i = 0; i < v6.gap_pos; i++) t[i] = g[i];
         for (i = 0; i < k; i++) t[8-k+i] = g[v6.gap_pos+i];
         for (i = 0; i < 8; i++) g[i] = t[i];
         n = 8;
      end
      return n == 8;
   endfunction

   function automatic void addr_take(input logic [7:0] c);
      if (c == CH_COLON && !v6.tail) v4_clear();
      else v4_take(c);
      v6_take(c);
   endfunction

   function automatic void cand_clear();
      tok = '0;
      prefix = 0;
      v4_clear();
      for (int i = 0; i < 8; i++) groups[i] = 0;
      v6 = '0;
   endfunction

   function automatic void cand_take(input logic [7:0] c);
      if (!tok.started) begin
         tok.started = 1;
         if (c == CH_LBRACK) begin
            tok.bracket = 1;
            return;
         end
      end
      if (tok.bracket) begin
         if (tok.closed) return;
         if (c == CH_RBRACK) begin
            tok.closed = 1;
            return;
         end
         addr_take(c);
         return;
      end
      if (c == CH_COLON) begin
         if (tok.colons == 0) begin
            tok.prefix_ok = v4_done();
            prefix = v4_word();
         end
         if (tok.colons < 2) tok.colons++;
      end
      addr_take(c);
   endfunction

   function automatic bit private_v4(input logic [31:0] a);
      return a[31:24] == 8'h0A || (a & 32'hFFF00000) == 32'hAC100000 ||
             a[31:16] == 16'hC0A8 || a[31:24] == 8'h7F || a[31:16] == 16'hA9FE ||
             (a & 32'hFFC00000) == 32'h64400000;
   endfunction

   function automatic bit private_v6(input logic [63:0] hi, input logic [63:0] lo);
      if (hi == 0 && lo == 1) return 1;
      if ((hi[63:48] & 16'hFFC0) == 16'hFE80 || (hi[63:48] & 16'hFFC0) == 16'hFEC0) return 1;
      return (hi[63:56] & 8'hFE) == 8'hFC;
   endfunction

   function automatic void judge_candidate();
      bit ok, is6, priv;
      logic [63:0] hi, lo;
      logic [15:0] g[8];
      hi = 0;
      lo = 0;
      is6 = 0;
      if (tok.bracket) begin
         ok = v6_assemble(g) && tok.closed;
         is6 = 1;
      end else if (tok.colons == 0) begin
         ok = v4_done();
         lo = v4_word();
      end else if (tok.colons == 1) begin
         ok = tok.prefix_ok;
         lo = prefix;
      end else begin
         ok = v6_assemble(g);
         is6 = 1;
      end
      if (!ok) return;
      if (is6) begin
         hi = {g[0], g[1], g[2], g[3]};
         lo = {g[4], g[5], g[6], g[7]};
         if (hi == 0 && lo[63:32] == 32'h0000FFFF) begin
            is6 = 0;
            lo = {32'h0, lo[31:0]};
         end
      end
      if (best.found && best.is_public) return;
      priv = is6 ? private_v6(hi, lo) : private_v4(lo[31:0]);
      if (!priv || !best.found) begin
         best.found = 1;
         best.is_public = !priv;
         best.is_v6 = is6;
         best_hi = hi;
         best_lo = lo;
      end
   endfunction

   function automatic void header_restart();
      syn = SYN_BETWEEN;
      key = KEY_NONE;
      want = 0;
      esc = 0;
      cand_clear();
      best_hi = 0;
      best_lo = 0;
      best = '0;
   endfunction

   function automatic void forwarded_byte(input logic [7:0] c, input bit last);
      logic [7:0] lc;
      lc = c | 8'h20;
      case (syn)
         SYN_BETWEEN: begin
            if (!is_delim(c)) begin
               key = (lc == "f") ? KEY_F : KEY_FAIL;
               syn = SYN_KEY;
            end
         end
         SYN_KEY: begin
            if (c == CH_EQUAL) begin
               want = (key == KEY_FOR);
               syn = SYN_BEFORE;
            end else if (key == KEY_F && lc == "o") key = KEY_FO;
            else if (key == KEY_FO && lc == "r") key = KEY_FOR;
            else key = KEY_FAIL;
         end
         SYN_BEFORE: begin
            if (c == CH_QUOTE) begin
               cand_clear();
               esc = 0;
               syn = SYN_QUOTED;
            end else if (is_delim(c)) syn = SYN_BETWEEN;
            else begin
               cand_clear();
               cand_take(c);
               syn = SYN_TOKEN;
            end
         end
         SYN_TOKEN: begin
            if (is_delim(c)) begin
               if (want) judge_candidate();
               syn = SYN_BETWEEN;
            end else begin
               cand_take(c);
               if (last && want) judge_candidate();
            end
         end
         SYN_QUOTED: begin
            if (esc) begin
               cand_take(c);
               esc = 0;
            end else if (c == CH_QUOTE) begin
               if (want) judge_candidate();
               syn = SYN_BETWEEN;
            end else begin
               if (c == CH_BSLASH) esc = 1;
               cand_take(c);
            end
         end
         default: syn = SYN_BETWEEN;
      endcase
   endfunction

   function automatic void list_byte(input logic [7:0] c, input bit last);
      if (syn != SYN_TOKEN) begin
         if (c != CH_SPACE && c != CH_COMMA) begin
            cand_clear();
            cand_take(c);
            syn = SYN_TOKEN;
         end
      end else if (c == CH_COMMA) begin
         judge_candidate();
         syn = SYN_BETWEEN;
      end else begin
         cand_take(c);
      end
      if (last && syn == SYN_TOKEN) judge_candidate();
   endfunction

   function automatic void predict_byte(input byte_item it);
      addr_result r;
      if (mode) list_byte(it.ch, it.last);
      else forwarded_byte(it.ch, it.last);
      if (!it.last) return;
      r = '0;
      if (best.found) begin
         r.status = best.is_public ? STATUS_PUBLIC : STATUS_PRIVATE;
         r.is_v6 = best.is_v6;
         r.hi = best_hi;
         r.lo = best_lo;
      end
      expected_addrs.push_back(r);
      header_restart();
   endfunction

   // Driver: one request per accepted handshake, gaps at random outside the quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (pending_bytes.size() > 0 && (idle_free || $urandom_range(99) >= 7)) begin
         req_tvalid <= 1;
         req_tdata <= pending_bytes[0].ch;
         req_tlast <= pending_bytes[0].last;
         predict_byte(pending_bytes.pop_front());
      end else begin
         req_tvalid <= 0;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= idle_free || $urandom_range(99) >= 7;
   end

   always @(posedge clock) begin
      addr_result got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[130:67], rsp_tdata[66:3], rsp_tdata[2], rsp_tdata[1:0]} == 0 ?
               '0 : '0;
         got.status = rsp_tdata[1:0];
         got.is_v6 = rsp_tdata[2];
         got.hi = rsp_tdata[66:3];
         got.lo = rsp_tdata[130:67];
         if (expected_addrs.size() == 0) begin
            report("unexpected result", got, 0);
         end else begin
            exp = expected_addrs.pop_front();
            if (got.status != exp.status) report("status", got.status, exp.status);
            if (got.is_v6 != exp.is_v6) report("is_v6", got.is_v6, exp.is_v6);
            if (got.hi != exp.hi) report("addr_high", got.hi, exp.hi);
            if (got.lo != exp.lo) report("addr_low", got.lo, exp.lo);
            header_count++;
            case (exp.status)
               STATUS_PUBLIC: public_count++;
               STATUS_PRIVATE: private_count++;
               default: none_count++;
            endcase
            if (exp.is_v6) v6_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("timeout with %0d results outstanding", expected_addrs.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back({s[i], i == s.len() - 1});
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || req_tvalid || expected_addrs.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes parse_mode through a setup phase and an access phase, then reads it back.
   task automatic write_mode(input bit value);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= {REG_PARSE_MODE, 2'b00};
      csr_pwdata <= {$urandom() & 32'hFFFFFFFE, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_penable <= 0;
      csr_pwrite <= 0;
      mode = value;
      header_restart();
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      if (csr_prdata[0] !== value) report("parse_mode readback", csr_prdata, value);
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   function automatic string rand_v4(input bit priv);
      string s;
      case (priv ? $urandom_range(5) : 6)
         0: s = "10";
         1: s = $sformatf("172.%0d", 16 + $urandom_range(15));
         2: s = "192.168";
         3: s = "127";
         4: s = "169.254";
         5: s = $sformatf("100.%0d", 64 + $urandom_range(63));
         default: s = $sformatf("%0d", $urandom_range(255));
      endcase
      while (1) begin
         int n;
         n = 1;
         for (int i = 0; i < s.len(); i++) if (s[i] == ".") n++;
         if (n == 4) break;
         s = {s, $sformatf(".%0d", $urandom_range(255))};
      end
      return s;
   endfunction

   function automatic string rand_v6();
      string s;
      int n, gap;
      string pre[4];
      pre[0] = "fe80";
      pre[1] = "fc00";
      pre[2] = "2001";
      pre[3] = "fec0";
      n = $urandom_range(7);
      case ($urandom_range(5))
         0: return "::1";
         1: return {"::ffff:", rand_v4($urandom_range(1))};
         2: return {"::FFFF:", $sformatf("%0h:%0h", $urandom_range(65535), $urandom_range(65535))};
         default: ;
      endcase
      gap = $urandom_range(3) == 0 ? -1 : $urandom_range(7);
      s = pre[$urandom_range(3)];
      for (int i = 1; i < 8; i++) begin
         if (i == gap) begin
            s = {s, "::"};
            i += $urandom_range(2);
            continue;
         end
         if (s[s.len()-1] != ":") s = {s, ":"};
         if (i == 6 && $urandom_range(3) == 0) begin
            s = {s, rand_v4(0)};
            break;
         end
         s = {s, $sformatf($urandom_range(1) ? "%0h" : "%0H", $urandom_range(65535))};
      end
      return s;
   endfunction

   function automatic string rand_noise(input int len);
      string s;
      string alphabet;
      alphabet = "0123456789abcdefABCDEF.:[]\"\\=,; forFOR";
      s = "";
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) s = {s, string'(8'($urandom_range(255)))};
         else s = {s, string'(alphabet[$urandom_range(alphabet.len() - 1)])};
      end
      if (s.len() == 0) s = "x";
      return s;
   endfunction

   function automatic string rand_candidate();
      string s;
      case ($urandom_range(9))
         0, 1: s = rand_v4($urandom_range(1));
         2: s = {rand_v4($urandom_range(1)), ":", $sformatf("%0d", $urandom_range(65535))};
         3, 4: s = {"[", rand_v6(), "]"};
         5: s = {"[", rand_v6(), "]:", $sformatf("%0d", $urandom_range(9999))};
         6: s = rand_v6();
         7: s = rand_noise($urandom_range(1, 6));
         default: begin
            s = rand_v4(0);
            s[$urandom_range(s.len() - 1)] = "0" + $urandom_range(9);
         end
      endcase
      return s;
   endfunction

   function automatic string rand_header(input bit list_mode);
      string s, key_name;
      int n;
      string keys[5];
      keys[0] = "for";
      keys[1] = "For";
      keys[2] = "proto";
      keys[3] = "by";
      keys[4] = "FOR";
      n = $urandom_range(1, 3);
      s = "";
      if ($urandom_range(19) == 0) return rand_noise($urandom_range(1, 12));
      for (int i = 0; i < n; i++) begin
         if (list_mode) begin
            s = {s, i ? "," : "", $urandom_range(1) ? " " : "", rand_candidate()};
         end else begin
            key_name = keys[$urandom_range(4)];
            if (i) s = {s, $urandom_range(1) ? ";" : ", "};
            if ($urandom_range(2) == 0)
               s = {s, key_name, "=\"", rand_candidate(), $urandom_range(9) ? "\"" : ""};
            else
               s = {s, key_name, "=", rand_candidate()};
         end
      end
      return s;
   endfunction

   initial begin
      int phase_items;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      rsp_tready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      idle_free = 0;
      mode = 0;
      header_restart();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: forwarded syntax first, at the reset mode.
      queue_text("for=203.0.113.7");
      queue_text("For=\"[2001:db8::1]:443\";proto=https, for=10.0.0.1");
      queue_text("by=1.2.3.4;for=192.168.0.1:80");
      queue_text("for=\"::ffff:8.8.8.8\"");
      queue_text("for=\"a\\\"b\"");
      queue_text("for=\"1.2.3.4");
      queue_text("for=0.0.0.0, for=255.255.255.255");
      pending_bytes.push_back({8'h00, 1'b0});
      pending_bytes.push_back({8'hFF, 1'b1});
      queue_text(";");
      drain();

      write_mode(1);
      queue_text("  10.1.2.3, 8.8.4.4:53 , fe80::1");
      queue_text("[fc00::2]x,::1");
      queue_text("1.2.3.04,256.1.1.1,::ffff:127.0.0.1");
      queue_text(",, ");
      queue_text("1:2:3:4:5:6:7:8");
      drain();
      write_mode(0);

      // Random: mixed phases of both modes, one stretch with no gaps at all.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3) idle_free = 1;
         if (phase == 5) idle_free = 0;
         write_mode(phase[0]);
         phase_items = 0;
         while (phase_items < 100) begin
            string h;
            h = rand_header(phase[0]);
            queue_text(h);
            phase_items += h.len();
         end
         drain();
      end
      $display("%0d header values checked: %0d public, %0d private, %0d without address",
               header_count, public_count, private_count, none_count);
      $display("%0d IPv6 results, both parse modes, random gaps on both sides", v6_count);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fcie_pkg.sv
rtl/core/fcie_cand.sv
rtl/core/fcie_select.sv
rtl/core/forwarded_client_ip_extractor.sv
test/forwarded_client_ip_extractor_test.sv
